FILE: design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

FILE: design/rvse_pkg.sv
`timescale 1ns / 1ps

package rvse_pkg;

  // history ring
  localparam int HISTORY_DEPTH = 256;
  localparam int ADDR_W        = $clog2(HISTORY_DEPTH);

  // field and accumulator widths
  localparam int PRICE_W = 24;
  localparam int VOL_W   = 24;
  localparam int PROD_W  = PRICE_W + VOL_W;
  localparam int ENTRY_W = PRICE_W + VOL_W;
  localparam int WSUM_W  = 56;
  localparam int VSUM_W  = 32;
  localparam int BARS_W  = 9;
  localparam int WIN_W   = 9;
  localparam int VWAP_W  = 32;
  localparam int SLOPE_W = 33;
  localparam int AVG_W   = 34;
  localparam int DIFF_W  = 35;
  localparam int CFG_W   = 8;

  // shared divider
  localparam int REM_W      = 33;
  localparam int NUM_W      = 35;
  localparam int DIVR_W     = 32;
  localparam int STEP_W     = 6;
  localparam int VWAP_STEPS = 32;
  localparam int EMA_STEPS  = 35;
  localparam int Q_FRAC     = 8;

  localparam logic [BARS_W-1:0] BARS_MAX     = '1;
  localparam logic [CFG_W-1:0]  PERIOD_RESET = 8'd50;
  localparam logic [CFG_W-1:0]  SMOOTH_RESET = 8'd5;

  // apb port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register select taken from the word address
  typedef enum logic [0:0] {
    REG_PERIOD = 1'b0,
    REG_SMOOTH = 1'b1
  } reg_sel_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SUB,
    S_ADD,
    S_VSTART,
    S_VWAIT,
    S_SLOPE,
    S_EWAIT,
    S_OUT
  } state_t;

  // divider control and status
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: design/rolling_vwap_slope_ema_core.sv
`timescale 1ns / 1ps
// Rolling VWAP with an EMA-smoothed slope.
// Input channel: one word per bar (close_price, bar_volume) on in_valid / in_stall.
// Output channel: one word per bar (smoothed_slope, window_vwap) on out_valid /
// out_stall, held in an output register until taken.
// Configuration: APB registers period_bars (0x0) and smoothing_count (0x4);
// a write restarts the window and the previous VWAP, the EMA is kept.
// in_stall is low only between bars, so a bar is accepted only after the last
// one is loaded; the divide for the VWAP is skipped when the window volume sum
// is zero. The shared divider takes 32 steps for the VWAP quotient and 35 steps
// for the EMA step.
// The history ring sits in one 48-bit RAM; each bar does one read of the bar
// that leaves the window and one write, and one 24x24 multiplier forms both
// the leaving and the entering price*volume product.
// Reset: synchronous, clears sums, counts, previous VWAP, EMA and the output
// valid; registers return to 50 and 5. The ring needs no clearing pass.
// Stall: a waiting output word holds the sequencer in S_OUT; the next bar is
// not accepted until the word is loaded into the output register.

`include "assert_macros.svh"

module rolling_vwap_slope_ema_core import rvse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // bar input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PRICE_W-1:0]       close_price,
  input  logic [VOL_W-1:0]         bar_volume,
  // result output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SLOPE_W-1:0] smoothed_slope,
  output logic [VWAP_W-1:0]        window_vwap,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  state_t state, state_next;

  // configuration and window state
  logic [CFG_W-1:0]  period_bars;
  logic [CFG_W-1:0]  smoothing_count;
  logic [WSUM_W-1:0] weighted_sum;
  logic [VSUM_W-1:0] volume_total;
  logic [BARS_W-1:0] bars_seen;
  logic [ADDR_W-1:0] ring_pointer;
  logic [VWAP_W-1:0] previous_vwap;
  logic signed [AVG_W-1:0] slope_average;

  // per-bar working registers
  logic [PRICE_W-1:0] price_q;
  logic [VOL_W-1:0]   vol_q;
  logic               drop;
  logic [PROD_W-1:0]  prod;
  logic [VWAP_W-1:0]  vwap;
  logic               diff_neg;

  // combinational helpers
  logic               in_acc;
  logic               out_load;
  logic               cfg_wr;
  reg_sel_t           cfg_sel;
  logic [WIN_W-1:0]   window;
  logic [ADDR_W-1:0]  old_addr;
  logic [ADDR_W-1:0]  ring_inc;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [PRICE_W-1:0] old_price;
  logic [VOL_W-1:0]   old_vol;
  logic [PRICE_W-1:0] mul_a;
  logic [VOL_W-1:0]   mul_b;
  logic               mul_old;
  logic               ram_re;
  logic               ram_we;
  logic [CFG_W-1:0]   smooth_eff;
  logic signed [SLOPE_W-1:0] slope;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]  diff_mag;
  logic signed [DIFF_W-1:0]  ema_step;
  logic signed [DIFF_W-1:0]  avg_sum;

  // divider hookup
  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [REM_W-1:0]  div_rem_init;
  logic [NUM_W-1:0]  div_num_init;
  logic [DIVR_W-1:0] div_divisor;
  logic [NUM_W-1:0]  div_quot;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // apb decode, word addressed
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_sel_t'(paddr[2]);

  always_comb begin
    case (cfg_sel)
      REG_PERIOD: prdata = APB_DW'(period_bars);
      REG_SMOOTH: prdata = APB_DW'(smoothing_count);
      default:    prdata = '0;
    endcase
  end

  // window length and the slot of the bar that leaves it
  always_comb begin
    if (int'(period_bars) + 1 > HISTORY_DEPTH) begin
      window = WIN_W'(HISTORY_DEPTH);
    end else begin
      window = WIN_W'(period_bars) + WIN_W'(1);
    end
    if (int'(ring_pointer) >= int'(window)) begin
      old_addr = ADDR_W'(int'(ring_pointer) - int'(window));
    end else begin
      old_addr = ADDR_W'(int'(ring_pointer) + HISTORY_DEPTH - int'(window));
    end
    if (ring_pointer == ADDR_W'(HISTORY_DEPTH - 1)) begin
      ring_inc = '0;
    end else begin
      ring_inc = ring_pointer + ADDR_W'(1);
    end
  end

  assign old_price = ram_rdata[ENTRY_W-1:VOL_W];
  assign old_vol   = ram_rdata[VOL_W-1:0];

  // shared multiplier operands
  assign mul_a = mul_old ? old_price : price_q;
  assign mul_b = mul_old ? old_vol : vol_q;

  // slope and ema difference
  assign smooth_eff = (smoothing_count == '0) ? CFG_W'(1) : smoothing_count;
  assign slope    = $signed({1'b0, vwap}) - $signed({1'b0, previous_vwap});
  assign diff     = $signed({{(DIFF_W-SLOPE_W){slope[SLOPE_W-1]}}, slope})
                  - $signed({{(DIFF_W-AVG_W){slope_average[AVG_W-1]}}, slope_average});
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign ema_step = diff_neg ? -$signed(div_quot) : $signed(div_quot);
  assign avg_sum  = $signed({{(DIFF_W-AVG_W){slope_average[AVG_W-1]}}, slope_average})
                  + ema_step;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_acc) state_next = S_READ;
      S_READ:   state_next = S_SUB;
      S_SUB:    state_next = S_ADD;
      S_ADD:    state_next = S_VSTART;
      S_VSTART: state_next = (volume_total == '0) ? S_SLOPE : S_VWAIT;
      S_VWAIT:  if (div_sts.done) state_next = S_SLOPE;
      S_SLOPE:  state_next = S_EWAIT;
      S_EWAIT:  if (div_sts.done) state_next = S_OUT;
      S_OUT:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    mul_old       = 1'b0;
    div_ctl.start = 1'b0;
    div_ctl.steps = STEP_W'(VWAP_STEPS);
    div_rem_init  = '0;
    div_num_init  = '0;
    div_divisor   = '0;
    case (state)
      S_IDLE: ram_re = in_acc;
      S_READ: mul_old = 1'b1;
      S_SUB:  ram_we = 1'b1;
      S_VSTART: begin
        // (weighted_sum << 8) / volume_total, quotient fits 32 bits
        div_ctl.start = (volume_total != '0);
        div_ctl.steps = STEP_W'(VWAP_STEPS);
        div_rem_init  = REM_W'(weighted_sum[WSUM_W-1:VWAP_W-Q_FRAC]);
        div_num_init  = {weighted_sum[VWAP_W-Q_FRAC-1:0], {Q_FRAC{1'b0}},
                         {(NUM_W-VWAP_W){1'b0}}};
        div_divisor   = volume_total;
      end
      S_SLOPE: begin
        // |slope - ema| / n
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(EMA_STEPS);
        div_num_init  = diff_mag;
        div_divisor   = DIVR_W'(smooth_eff);
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window state, configuration and ema
  always_ff @(posedge clk) begin
    if (rst) begin
      period_bars     <= PERIOD_RESET;
      smoothing_count <= SMOOTH_RESET;
      weighted_sum    <= '0;
      volume_total    <= '0;
      bars_seen       <= '0;
      ring_pointer    <= '0;
      previous_vwap   <= '0;
      slope_average   <= '0;
    end else begin
      case (state)
        S_SUB: begin
          if (drop) begin
            weighted_sum <= weighted_sum - WSUM_W'(prod);
            volume_total <= volume_total - VSUM_W'(old_vol);
          end
        end
        S_ADD: begin
          weighted_sum <= weighted_sum + WSUM_W'(prod);
          volume_total <= volume_total + VSUM_W'(vol_q);
          ring_pointer <= ring_inc;
          if (bars_seen != BARS_MAX) begin
            bars_seen <= bars_seen + BARS_W'(1);
          end
        end
        S_SLOPE: previous_vwap <= vwap;
        S_EWAIT: begin
          if (div_sts.done) begin
            slope_average <= avg_sum[AVG_W-1:0];
          end
        end
        default: begin
        end
      endcase
      // a register write restarts the window
      if (cfg_wr) begin
        case (cfg_sel)
          REG_PERIOD: period_bars <= pwdata[CFG_W-1:0];
          REG_SMOOTH: smoothing_count <= pwdata[CFG_W-1:0];
          default: begin
          end
        endcase
        weighted_sum  <= '0;
        volume_total  <= '0;
        bars_seen     <= '0;
        ring_pointer  <= '0;
        previous_vwap <= '0;
      end
    end
  end

  // per-bar working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      price_q <= close_price;
      vol_q   <= bar_volume;
      drop    <= (bars_seen >= BARS_W'(window));
    end
    if (state == S_READ || state == S_SUB) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_VSTART && volume_total == '0) begin
      vwap <= '0;
    end else if (state == S_VWAIT && div_sts.done) begin
      vwap <= div_quot[VWAP_W-1:0];
    end
    if (state == S_SLOPE) begin
      diff_neg <= diff[DIFF_W-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      smoothed_slope <= slope_average[SLOPE_W-1:0];
      window_vwap    <= vwap;
    end
  end

  // history ring, price above volume
  rvse_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_pointer),
    .wdata ({price_q, vol_q}),
    .re    (ram_re),
    .raddr (old_addr),
    .rdata (ram_rdata)
  );

  // shared divider
  rvse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .rem_init (div_rem_init),
    .num_init (div_num_init),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  // checks
  `ASSERT_PROP(a_div_start_idle, clk, rst, div_ctl.start |-> !div_sts.busy, "divider restarted while busy")
  `ASSERT_PROP(a_ready_div_idle, clk, rst, !in_stall |-> !div_sts.busy, "input ready with divider running")
  `ASSERT_PROP(a_vwap_fits, clk, rst, (state == S_VWAIT && div_sts.done) |-> (div_quot[NUM_W-1:VWAP_W] == '0), "vwap quotient overflow")
  `ASSERT_NEVER(a_sum_consistent, clk, rst, state == S_IDLE && volume_total == '0 && weighted_sum != '0, "weighted sum without volume")

endmodule

FILE: design/rvse_ram.sv
`timescale 1ns / 1ps

module rvse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/rvse_div.sv
`timescale 1ns / 1ps

module rvse_div import rvse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_ctl_t          ctl,
  input  logic [REM_W-1:0]  rem_init,
  input  logic [NUM_W-1:0]  num_init,
  input  logic [DIVR_W-1:0] divisor,
  output div_sts_t          sts,
  output logic [NUM_W-1:0]  quot
);

  logic [REM_W-1:0]  rem;
  logic [NUM_W-1:0]  num;
  logic [DIVR_W-1:0] dvr;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [REM_W:0]    trial;
  logic [REM_W:0]    trial_sub;
  logic              fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem, num[NUM_W-1]};
    fits      = trial >= (REM_W+1)'(dvr);
    trial_sub = trial - (REM_W+1)'(dvr);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= rem_init;
      num <= num_init;
      dvr <= divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      num <= {num[NUM_W-2:0], fits};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quot     = num;

endmodule
